### rtl/rv64i_integer_execute_core_defines.svh
// ----------------------------------------------------------------------------
// RV64I integer execute core: assertion macros
// Plain and implication property checks used by the core's back end.
// ----------------------------------------------------------------------------
`ifndef RV64I_INTEGER_EXECUTE_CORE_DEFINES_SVH
`define RV64I_INTEGER_EXECUTE_CORE_DEFINES_SVH

`ifndef SYNTH
`define RVX_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rvx assertion failed");
`define RVX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rvx implication failed");
`else
`define RVX_ASSERT(lbl, clk, rstn, prop)
`define RVX_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// RV64I integer execute core package
// Widths, opcodes, status codes and the types shared between front and back.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int XLEN        = 64;
    localparam int ILEN        = 32;
    localparam int REG_COUNT   = 32;
    localparam int REG_AW      = $clog2(REG_COUNT);
    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_ALUI   = 7'h13;
    localparam logic [6:0] OPC_ALUR   = 7'h33;
    localparam logic [6:0] OPC_ALUIW  = 7'h1B;
    localparam logic [6:0] OPC_ALURW  = 7'h3B;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [ILEN-1:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [ILEN-1:0] WORD_EBREAK = 32'h0010_0073;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_BASE = 6'h00;
    localparam logic [5:0] F6_ALT  = 6'h10;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LD  = 3'd3;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_LWU = 3'd6;
    localparam logic [2:0] F3_BAD = 3'd7;

    localparam logic [1:0] ST_NORMAL  = 2'd0;
    localparam logic [1:0] ST_ECALL   = 2'd1;
    localparam logic [1:0] ST_EBREAK  = 2'd2;
    localparam logic [1:0] ST_ILLEGAL = 2'd3;

    typedef enum logic [3:0] {
        OP_LUI,
        OP_AUIPC,
        OP_JAL,
        OP_JALR,
        OP_BRANCH,
        OP_LOAD,
        OP_STORE,
        OP_ALUI,
        OP_ALUR,
        OP_ALUIW,
        OP_ALURW,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [2:0]        f3;
        logic              alt;
        logic [REG_AW-1:0] rs1;
        logic [REG_AW-1:0] rs2;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   imm;
        logic [1:0]        status;
    } t_uop;

    typedef struct packed {
        logic valid;
        t_uop uop;
    } t_front_stat;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_ctl;

endpackage

### rtl/rvx_instr_if.sv
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel that carries one instruction word per item.
// ----------------------------------------------------------------------------
interface rvx_instr_if import rvx_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ILEN-1:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

### rtl/rvx_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one execution result per item.
// ----------------------------------------------------------------------------
interface rvx_result_if import rvx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [XLEN-1:0]   next_pc;
    logic              reg_written;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
    logic [1:0]        status;

    modport source (output valid, output next_pc, output reg_written, output dest_index,
                    output dest_value, output status, input ready);
    modport sink   (input valid, input next_pc, input reg_written, input dest_index,
                    input dest_value, input status, output ready);
endinterface

### rtl/rvx_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/rvx_front.sv
// ----------------------------------------------------------------------------
// RV64I front end
// Accepts instruction words, decodes format, legality and immediate, and
// holds the decoded items in a short queue for the back end.
// ----------------------------------------------------------------------------
module rvx_front import rvx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvx_instr_if.sink   i_instr,
    input  t_back_ctl   i_back,
    output t_front_stat o_front
);
    t_uop              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;
    t_uop              dec;
    logic [ILEN-1:0]   w;
    logic [6:0]        opc;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [5:0]        f6;
    logic              bad;

    assign i_instr.ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH)) && !i_back.clearing;
    assign push = i_instr.valid && i_instr.ready;
    assign pop  = i_back.pop && (r_count != '0);

    assign w   = i_instr.instruction_word;
    assign opc = w[6:0];
    assign f3  = w[14:12];
    assign f7  = w[31:25];
    assign f6  = w[31:26];

    always_comb begin
        bad        = 1'b0;
        dec.op     = OP_NONE;
        dec.f3     = f3;
        dec.alt    = 1'b0;
        dec.rs1    = w[19:15];
        dec.rs2    = w[24:20];
        dec.rd     = w[11:7];
        dec.imm    = {{(XLEN-12){w[31]}}, w[31:20]};
        dec.status = ST_NORMAL;
        unique case (opc)
            OPC_LUI: begin
                dec.op  = OP_LUI;
                dec.imm = {{(XLEN-32){w[31]}}, w[31:12], 12'b0};
            end
            OPC_AUIPC: begin
                dec.op  = OP_AUIPC;
                dec.imm = {{(XLEN-32){w[31]}}, w[31:12], 12'b0};
            end
            OPC_JAL: begin
                dec.op  = OP_JAL;
                dec.imm = {{(XLEN-21){w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_JALR: begin
                dec.op = OP_JALR;
                bad    = (f3 != 3'd0);
            end
            OPC_BRANCH: begin
                dec.op  = OP_BRANCH;
                dec.imm = {{(XLEN-13){w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                bad     = (f3 == 3'd2) || (f3 == 3'd3);
            end
            OPC_LOAD: begin
                dec.op = OP_LOAD;
                bad    = (f3 == F3_BAD);
            end
            OPC_STORE: begin
                dec.op  = OP_STORE;
                dec.imm = {{(XLEN-12){w[31]}}, w[31:25], w[11:7]};
                bad     = f3[2];
            end
            OPC_ALUI: begin
                dec.op = OP_ALUI;
                if (f3 == F3_SLL) begin
                    bad = (f6 != F6_BASE);
                end else if (f3 == F3_SR) begin
                    bad     = (f6 != F6_BASE) && (f6 != F6_ALT);
                    dec.alt = (f6 == F6_ALT);
                end
            end
            OPC_ALUR: begin
                dec.op  = OP_ALUR;
                dec.alt = (f7 == F7_ALT);
                bad     = !((f7 == F7_BASE) ||
                            ((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR))));
            end
            OPC_ALUIW: begin
                dec.op  = OP_ALUIW;
                dec.alt = (f3 == F3_SR) && (f7 == F7_ALT);
                bad     = !((f3 == F3_ADD) ||
                            ((f3 == F3_SLL) && (f7 == F7_BASE)) ||
                            ((f3 == F3_SR) && ((f7 == F7_BASE) || (f7 == F7_ALT))));
            end
            OPC_ALURW: begin
                dec.op  = OP_ALURW;
                dec.alt = (f7 == F7_ALT);
                bad     = !(((f3 == F3_ADD) && ((f7 == F7_BASE) || (f7 == F7_ALT))) ||
                            ((f3 == F3_SLL) && (f7 == F7_BASE)) ||
                            ((f3 == F3_SR) && ((f7 == F7_BASE) || (f7 == F7_ALT))));
            end
            OPC_FENCE: begin
                bad = (f3 != 3'd0);
            end
            OPC_SYSTEM: begin
                if (w == WORD_ECALL) begin
                    dec.status = ST_ECALL;
                end else if (w == WORD_EBREAK) begin
                    dec.status = ST_EBREAK;
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        // An illegal word turns into a no-op that only reports its status.
        if (bad) begin
            dec.op     = OP_NONE;
            dec.status = ST_ILLEGAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_front.valid = (r_count != '0);
    assign o_front.uop   = r_q[r_rd_ptr];
endmodule

### rtl/rvx_back.sv
// ----------------------------------------------------------------------------
// RV64I back end
// Sequencer that reads the register file, executes one decoded item, walks
// the data memory a byte per cycle, writes back and registers the result.
// ----------------------------------------------------------------------------
`include "rv64i_integer_execute_core_defines.svh"

module rvx_back import rvx_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [XLEN-1:0] i_cfg_wdata,
    input  t_front_stat   i_front,
    output t_back_ctl     o_back,
    rvx_result_if.source  o_result
);
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MEM   = 5'b01000,
        S_WB    = 5'b10000
    } t_state;

    t_state              r_state;
    logic [XLEN-1:0]     r_pc;
    t_uop                r_uop;
    logic [XLEN-1:0]     r_val;
    logic [XLEN-1:0]     r_npc;
    logic [MEM_AW-1:0]   r_addr;
    logic [XLEN-1:0]     r_stdata;
    logic                r_wr;
    logic [3:0]          r_cnt;
    logic [MEM_AW-1:0]   r_clr;
    logic [REG_COUNT-1:0] r_rvalid;

    logic                r_out_valid;
    logic [XLEN-1:0]     r_out_npc;
    logic                r_out_wr;
    logic [REG_AW-1:0]   r_out_rd;
    logic [XLEN-1:0]     r_out_val;
    logic [1:0]          r_out_status;

    logic [XLEN-1:0]     rf_rd1;
    logic [XLEN-1:0]     rf_rd2;
    logic                rf_we;
    logic [7:0]          mem_rd;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_addr;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic [2:0]          ld_byte;

    logic                pop;
    logic                out_free;
    logic [XLEN-1:0]     a;
    logic [XLEN-1:0]     b;
    logic [XLEN-1:0]     opb;
    logic [XLEN-1:0]     sum;
    logic [XLEN-1:0]     diff;
    logic [XLEN-1:0]     pc_imm;
    logic [XLEN-1:0]     pc_4;
    logic [5:0]          sh;
    logic [4:0]          shw;
    logic                lt_s;
    logic                lt_u;
    logic                take;
    logic [31:0]         w32;
    logic [XLEN-1:0]     n_val;
    logic [XLEN-1:0]     n_npc;
    logic                n_wr;
    logic [3:0]          len;
    logic                is_load;
    logic                is_store;
    logic [XLEN-1:0]     wb_val;

    assign pop      = (r_state == S_IDLE) && i_front.valid;
    assign out_free = !r_out_valid || o_result.ready;
    assign o_back.pop      = pop;
    assign o_back.clearing = (r_state == S_CLEAR);

    // Two copies of the register file give both source operands in one read.
    assign rf_we = (r_state == S_WB) && out_free && r_wr;

    rvx_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_uop.rd),
        .i_wdata (wb_val),
        .i_raddr (i_front.uop.rs1),
        .o_rdata (rf_rd1)
    );

    rvx_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_uop.rd),
        .i_wdata (wb_val),
        .i_raddr (i_front.uop.rs2),
        .o_rdata (rf_rd2)
    );

    assign is_load  = (r_uop.op == OP_LOAD);
    assign is_store = (r_uop.op == OP_STORE);
    assign len      = 4'd1 << r_uop.f3[1:0];
    assign mem_addr = r_addr + MEM_AW'(r_cnt);
    // Read data comes from a registered port, so it belongs to the previous byte.
    assign ld_byte  = 3'(r_cnt - 4'd1);

    assign mem_we    = (r_state == S_CLEAR) ||
                       ((r_state == S_MEM) && is_store && (r_cnt != len));
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr : mem_addr;
    assign mem_wdata = (r_state == S_CLEAR) ? 8'h00 : r_stdata[8*r_cnt[2:0] +: 8];

    rvx_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_addr),
        .o_rdata (mem_rd)
    );

    // Operands: x0 and never-written registers read as zero.
    assign a = (r_rvalid[r_uop.rs1] && (r_uop.rs1 != '0)) ? rf_rd1 : '0;
    assign b = (r_rvalid[r_uop.rs2] && (r_uop.rs2 != '0)) ? rf_rd2 : '0;
    assign opb = ((r_uop.op == OP_ALUR) || (r_uop.op == OP_ALURW) ||
                  (r_uop.op == OP_BRANCH)) ? b : r_uop.imm;

    assign sum    = a + opb;
    assign diff   = a - opb;
    assign pc_imm = r_pc + r_uop.imm;
    assign pc_4   = r_pc + XLEN'(4);
    assign sh     = opb[5:0];
    assign shw    = opb[4:0];
    assign lt_s   = $signed(a) < $signed(opb);
    assign lt_u   = a < opb;

    always_comb begin
        take = 1'b0;
        unique case (r_uop.f3)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = lt_s;
            F3_BGE:  take = !lt_s;
            F3_BLTU: take = lt_u;
            F3_BGEU: take = !lt_u;
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        n_val = '0;
        n_npc = pc_4;
        n_wr  = 1'b0;
        w32   = '0;
        unique case (r_uop.op)
            OP_LUI: begin
                n_wr  = 1'b1;
                n_val = r_uop.imm;
            end
            OP_AUIPC: begin
                n_wr  = 1'b1;
                n_val = pc_imm;
            end
            OP_JAL: begin
                n_wr  = 1'b1;
                n_val = pc_4;
                n_npc = pc_imm;
            end
            OP_JALR: begin
                n_wr  = 1'b1;
                n_val = pc_4;
                n_npc = {sum[XLEN-1:1], 1'b0};
            end
            OP_BRANCH: begin
                n_npc = take ? pc_imm : pc_4;
            end
            OP_LOAD: begin
                n_wr = 1'b1;
            end
            OP_STORE: begin
                n_wr = 1'b0;
            end
            OP_ALUI, OP_ALUR: begin
                n_wr = 1'b1;
                unique case (r_uop.f3)
                    F3_ADD:  n_val = r_uop.alt ? diff : sum;
                    F3_SLL:  n_val = a << sh;
                    F3_SLT:  n_val = {{(XLEN-1){1'b0}}, lt_s};
                    F3_SLTU: n_val = {{(XLEN-1){1'b0}}, lt_u};
                    F3_XOR:  n_val = a ^ opb;
                    F3_SR:   n_val = r_uop.alt ? XLEN'($signed(a) >>> sh) : (a >> sh);
                    F3_OR:   n_val = a | opb;
                    F3_AND:  n_val = a & opb;
                    default: n_val = '0;
                endcase
            end
            OP_ALUIW, OP_ALURW: begin
                n_wr = 1'b1;
                unique case (r_uop.f3)
                    F3_ADD:  w32 = r_uop.alt ? diff[31:0] : sum[31:0];
                    F3_SLL:  w32 = a[31:0] << shw;
                    F3_SR:   w32 = r_uop.alt ? 32'($signed(a[31:0]) >>> shw)
                                             : (a[31:0] >> shw);
                    default: w32 = '0;
                endcase
                n_val = {{(XLEN-32){w32[31]}}, w32};
            end
            default: begin
                n_wr = 1'b0;
            end
        endcase
    end

    // Loads gather raw bytes in r_val; extension happens on write-back.
    always_comb begin
        wb_val = r_val;
        if (is_load) begin
            unique case (r_uop.f3)
                F3_LB:   wb_val = {{(XLEN-8){r_val[7]}}, r_val[7:0]};
                F3_LH:   wb_val = {{(XLEN-16){r_val[15]}}, r_val[15:0]};
                F3_LW:   wb_val = {{(XLEN-32){r_val[31]}}, r_val[31:0]};
                F3_LD:   wb_val = r_val;
                F3_LBU:  wb_val = {{(XLEN-8){1'b0}}, r_val[7:0]};
                F3_LHU:  wb_val = {{(XLEN-16){1'b0}}, r_val[15:0]};
                F3_LWU:  wb_val = {{(XLEN-32){1'b0}}, r_val[31:0]};
                default: wb_val = r_val;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_uop <= i_front.uop;
        end
        if (r_state == S_EXEC) begin
            r_val    <= n_val;
            r_npc    <= n_npc;
            r_wr     <= n_wr && (r_uop.rd != '0);
            r_addr   <= sum[MEM_AW-1:0];
            r_stdata <= b;
        end
        if ((r_state == S_MEM) && is_load && (r_cnt != '0)) begin
            r_val[8*ld_byte +: 8] <= mem_rd;
        end
        if ((r_state == S_WB) && out_free) begin
            r_out_npc    <= r_npc;
            r_out_wr     <= r_wr;
            r_out_rd     <= r_wr ? r_uop.rd : '0;
            r_out_val    <= r_wr ? wb_val : '0;
            r_out_status <= r_uop.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pc        <= '0;
            r_cnt       <= '0;
            r_clr       <= '0;
            r_rvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_cnt <= '0;
                    if (is_load || is_store) begin
                        r_state <= S_MEM;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_MEM: begin
                    if (r_cnt == len) begin
                        r_state <= S_WB;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_pc        <= r_npc;
                        if (r_wr) begin
                            r_rvalid[r_uop.rd] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
            if (i_cfg_we) begin
                r_pc <= i_cfg_wdata;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.next_pc     = r_out_npc;
    assign o_result.reg_written = r_out_wr;
    assign o_result.dest_index  = r_out_rd;
    assign o_result.dest_value  = r_out_val;
    assign o_result.status      = r_out_status;

    `RVX_ASSERT_IMP(a_no_pop_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_back.pop)
    `RVX_ASSERT_IMP(a_rf_we_wb, i_clk, i_rst_n, rf_we, (r_state == S_WB) && (r_uop.rd != '0))
    `RVX_ASSERT_IMP(a_mem_cnt, i_clk, i_rst_n, r_state == S_MEM, r_cnt <= len)
    `RVX_ASSERT_IMP(a_x0_quiet, i_clk, i_rst_n, r_out_valid && r_out_wr, r_out_rd != '0)
endmodule

### rtl/rv64i_integer_execute_core.sv
// An item enters the queue; the back end then reads registers, executes and
// writes back, with a memory phase before write-back for a load or store,
// since data memory is walked one byte per cycle.
// The back end takes a new item only after the last one is written back.
// Reset: synchronous, active low; pc becomes 0 and a clearing pass over all
// 4096 bytes zeroes data memory, during which no item is accepted.
// ----------------------------------------------------------------------------
// RV64I integer execute core
// Decoupled decode front end and sequenced execute back end with a queue.
// ----------------------------------------------------------------------------
module rv64i_integer_execute_core import rvx_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [XLEN-1:0] i_cfg_wdata,
    rvx_instr_if.sink       i_instr,
    rvx_result_if.source    o_result
);
    t_front_stat front_stat;
    t_back_ctl   back_ctl;

    rvx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_instr (i_instr),
        .i_back  (back_ctl),
        .o_front (front_stat)
    );

    rvx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_front     (front_stat),
        .o_back      (back_ctl),
        .o_result    (o_result)
    );
endmodule

### tb/rvx_tb_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The block's own channel interfaces are reused; this file adds only a result record type.
// ----------------------------------------------------------------------------
package rvx_tb_types;
    import rvx_pkg::*;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              reg_written;
        logic [REG_AW-1:0] dest_index;
        logic [XLEN-1:0]   dest_value;
        logic [1:0]        status;
    } t_exec_result;
endpackage

### tb/rvx_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Execution checker
// Watches the instruction and result channels, runs its own RV64I model on
// every accepted word and compares each result with the oldest expectation.
// ----------------------------------------------------------------------------
module rvx_exec_checker import rvx_pkg::*; import rvx_tb_types::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [XLEN-1:0] i_cfg_wdata,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  logic [ILEN-1:0] i_word,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  t_exec_result    i_result,
    output int              o_fail_count,
    output int              o_pending
);
    logic [XLEN-1:0] regs [REG_COUNT];
    logic [7:0]      mem  [MEM_BYTES];
    logic [XLEN-1:0] pc;
    t_exec_result    expected_q[$];

    function automatic logic [XLEN-1:0] sext(logic [XLEN-1:0] v, int bits);
        logic [XLEN-1:0] m;
        m = {XLEN{1'b1}} << bits;
        return v[bits-1] ? (v | m) : (v & ~m);
    endfunction

    function automatic logic [XLEN-1:0] mem_load(logic [XLEN-1:0] addr, int n);
        logic [XLEN-1:0] v;
        v = '0;
        for (int k = 0; k < n; k++)
            v |= XLEN'(mem[(addr + k) % MEM_BYTES]) << (8 * k);
        return v;
    endfunction

    function automatic t_exec_result execute_word(logic [ILEN-1:0] w);
        logic [6:0] opc, f7;
        logic [2:0] f3;
        logic [4:0] rd;
        logic [5:0] f6, sh6;
        logic [XLEN-1:0] a, b, npc, val, ad, imm_i, imm_s, imm_b, imm_u, imm_j;
        logic wr, bad, take;
        logic [1:0] st;
        t_exec_result r;
        opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25]; f6 = w[31:26];
        sh6 = w[25:20];
        a = regs[w[19:15]]; b = regs[w[24:20]];
        npc = pc + 4;
        imm_i = sext(XLEN'(w[31:20]), 12);
        imm_s = sext(XLEN'({w[31:25], w[11:7]}), 12);
        imm_b = sext(XLEN'({w[31], w[7], w[30:25], w[11:8], 1'b0}), 13);
        imm_u = sext(XLEN'({w[31:12], 12'h000}), 32);
        imm_j = sext(XLEN'({w[31], w[19:12], w[20], w[30:21], 1'b0}), 21);
        wr = 0; bad = 0; take = 0; val = '0; st = ST_NORMAL;
        case (opc)
            OPC_LUI: begin wr = 1; val = imm_u; end
            OPC_AUIPC: begin wr = 1; val = pc + imm_u; end
            OPC_JAL: begin wr = 1; val = pc + 4; npc = pc + imm_j; end
            OPC_JALR: begin
                if (f3 != 0) bad = 1;
                else begin
                    wr = 1; val = pc + 4; npc = (a + imm_i) & ~XLEN'(1);
                end
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = a == b;
                    F3_BNE:  take = a != b;
                    F3_BLT:  take = $signed(a) < $signed(b);
                    F3_BGE:  take = $signed(a) >= $signed(b);
                    F3_BLTU: take = a < b;
                    F3_BGEU: take = a >= b;
                    default: bad = 1;
                endcase
                if (take) npc = pc + imm_b;
            end
            OPC_LOAD: begin
                ad = a + imm_i; wr = 1;
                case (f3)
                    F3_LB:  val = sext(mem_load(ad, 1), 8);
                    F3_LH:  val = sext(mem_load(ad, 2), 16);
                    F3_LW:  val = sext(mem_load(ad, 4), 32);
                    F3_LD:  val = mem_load(ad, 8);
                    F3_LBU: val = mem_load(ad, 1);
                    F3_LHU: val = mem_load(ad, 2);
                    F3_LWU: val = mem_load(ad, 4);
                    default: bad = 1;
                endcase
            end
            OPC_STORE: begin
                if (f3 > 3) bad = 1;
                else begin
                    ad = a + imm_s;
                    for (int k = 0; k < (1 << f3); k++)
                        mem[(ad + k) % MEM_BYTES] = b[8*k +: 8];
                end
            end
            OPC_ALUI: begin
                wr = 1;
                case (f3)
                    F3_ADD:  val = a + imm_i;
                    F3_SLT:  val = XLEN'($signed(a) < $signed(imm_i));
                    F3_SLTU: val = XLEN'(a < imm_i);
                    F3_XOR:  val = a ^ imm_i;
                    F3_OR:   val = a | imm_i;
                    F3_AND:  val = a & imm_i;
                    F3_SLL:  if (f6 != F6_BASE) bad = 1; else val = a << sh6;
                    default: begin
                        if (f6 == F6_BASE) val = a >> sh6;
                        else if (f6 == F6_ALT) val = $signed(a) >>> sh6;
                        else bad = 1;
                    end
                endcase
            end
            OPC_ALUR: begin
                wr = 1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << b[5:0];
                        F3_SLT:  val = XLEN'($signed(a) < $signed(b));
                        F3_SLTU: val = XLEN'(a < b);
                        F3_XOR:  val = a ^ b;
                        F3_SR:   val = a >> b[5:0];
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR) val = $signed(a) >>> b[5:0];
                else bad = 1;
            end
            OPC_ALUIW, OPC_ALURW: begin
                logic [4:0] s5;
                logic [XLEN-1:0] rhs;
                logic regform;
                regform = opc == OPC_ALURW;
                s5 = regform ? b[4:0] : w[24:20];
                rhs = regform ? b : imm_i;
                wr = 1;
                if (f3 == F3_ADD && (!regform || f7 == F7_BASE)) val = sext(a + rhs, 32);
                else if (regform && f3 == F3_ADD && f7 == F7_ALT) val = sext(a - b, 32);
                else if (f3 == F3_SLL && f7 == F7_BASE) val = sext(a << s5, 32);
                else if (f3 == F3_SR && f7 == F7_BASE)
                    val = sext(XLEN'(a[31:0]) >> s5, 32);
                else if (f3 == F3_SR && f7 == F7_ALT)
                    val = sext($signed(sext(a, 32)) >>> s5, 32);
                else bad = 1;
            end
            OPC_FENCE: if (f3 != 0) bad = 1;
            OPC_SYSTEM: begin
                if (w == WORD_ECALL) st = ST_ECALL;
                else if (w == WORD_EBREAK) st = ST_EBREAK;
                else bad = 1;
            end
            default: bad = 1;
        endcase
        if (bad) begin
            wr = 0; st = ST_ILLEGAL; npc = pc + 4;
        end
        if (wr && rd != 0) regs[rd] = val;
        else begin
            wr = 0; rd = 0; val = '0;
        end
        pc = npc;
        r.next_pc = npc; r.reg_written = wr; r.dest_index = rd;
        r.dest_value = val; r.status = st;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_exec_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) regs[i] = '0;
            for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
            pc = '0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) pc = i_cfg_wdata;
            if (i_in_valid && i_in_ready) expected_q.push_back(execute_word(i_word));
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== i_result) begin
                        if (o_fail_count < 10)
                            $display("result differs: expected %p actual %p", exp_r, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV64I execute core testbench
// Drives directed and random instruction words under random stalls, loads
// several start addresses, and takes its verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
    import rvx_pkg::*;
    import rvx_tb_types::*;

    localparam int CYCLE_LIMIT = 600000;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [XLEN-1:0] cfg_wdata;
    int              fail_count;
    int              pending;
    int              cycle_count;
    t_exec_result    seen;

    rvx_instr_if  instr_ch ();
    rvx_result_if result_ch ();

    rv64i_integer_execute_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_instr     (instr_ch.sink),
        .o_result    (result_ch.source)
    );

    assign seen = '{result_ch.next_pc, result_ch.reg_written, result_ch.dest_index,
                    result_ch.dest_value, result_ch.status};

    rvx_exec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (instr_ch.valid),
        .i_in_ready   (instr_ch.ready),
        .i_word       (instr_ch.instruction_word),
        .i_out_valid  (result_ch.valid),
        .i_out_ready  (result_ch.ready),
        .i_result     (seen),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("rv64i_integer_execute_core: mismatch");
                $finish;
            end
        end
    end

    // The receiver drops ready for a random stall, sometimes none, before taking each item.
    initial begin
        int gap;
        result_ch.ready = 0;
        forever begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                result_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    function automatic logic [ILEN-1:0] r_type(logic [6:0] f7, logic [4:0] rs2,
            logic [4:0] rs1, logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [ILEN-1:0] i_type(logic [11:0] imm, logic [4:0] rs1,
            logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [ILEN-1:0] s_type(logic [11:0] imm, logic [4:0] rs2,
            logic [4:0] rs1, logic [2:0] f3, logic [6:0] opc);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
    endfunction

    // Valid stays high into the next item when no gap is drawn.
    task automatic send_word(logic [ILEN-1:0] w, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            instr_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        instr_ch.valid <= 1;
        instr_ch.instruction_word <= w;
        do @(posedge i_clk); while (!instr_ch.ready);
    endtask

    task automatic drain();
        instr_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_start(logic [XLEN-1:0] addr);
        drain();
        cfg_we <= 1;
        cfg_wdata <= addr;
        @(posedge i_clk);
        cfg_we <= 0;
    endtask

    // Mostly well-formed instructions from every group, with some raw noise.
    function automatic logic [ILEN-1:0] random_word();
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        logic [11:0] imm;
        rd = 5'($urandom_range(0, 31)); rs1 = 5'($urandom_range(0, 31));
        rs2 = 5'($urandom_range(0, 31));
        f3 = 3'($urandom_range(0, 7)); imm = 12'($urandom);
        case ($urandom_range(0, 15))
            0: return {20'($urandom_range(0, 20'hFFFFF)), rd, OPC_LUI};
            1: return {20'($urandom_range(0, 20'hFFFFF)), rd, OPC_AUIPC};
            2: return {20'($urandom_range(0, 20'hFFFFF)), rd, OPC_JAL};
            3: return i_type(imm, rs1, ($urandom_range(0, 7) == 0) ? f3 : 3'd0, rd, OPC_JALR);
            4: return s_type(imm, rs2, rs1, f3, OPC_BRANCH);
            5, 6: return i_type(imm, rs1, f3, rd, OPC_LOAD);
            7, 8: return s_type(imm, rs2, rs1, f3, OPC_STORE);
            9: begin
                if (f3 == F3_SLL || f3 == F3_SR)
                    imm[11:6] = ($urandom_range(0, 5) == 0) ? imm[11:6] :
                                ($urandom_range(0, 1) ? {F6_ALT} : {F6_BASE});
                return i_type(imm, rs1, f3, rd, OPC_ALUI);
            end
            10, 11: return r_type($urandom_range(0, 5) == 0 ? 7'($urandom) :
                                  ($urandom_range(0, 1) ? F7_ALT : F7_BASE),
                                  rs2, rs1, f3, rd, OPC_ALUR);
            12: return i_type({$urandom_range(0, 1) ? F7_ALT : F7_BASE, imm[4:0]},
                              rs1, f3, rd, OPC_ALUIW);
            13: return r_type($urandom_range(0, 1) ? F7_ALT : F7_BASE, rs2, rs1, f3, rd,
                              OPC_ALURW);
            14: return ($urandom_range(0, 1)) ? i_type(imm, rs1, f3, rd, OPC_FENCE)
                                              : i_type(imm, rs1, f3, rd, OPC_SYSTEM);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [ILEN-1:0] directed [$];
        instr_ch.valid = 0;
        instr_ch.instruction_word = '0;
        cfg_we = 0;
        cfg_wdata = '0;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        directed = '{
            {20'hFFFFF, 5'd1, OPC_LUI},
            i_type(12'h7FF, 5'd1, F3_ADD, 5'd2, OPC_ALUI),
            i_type(12'h800, 5'd0, F3_ADD, 5'd3, OPC_ALUI),
            i_type({F6_ALT, 6'd63}, 5'd1, F3_SR, 5'd4, OPC_ALUI),
            i_type({F6_BASE, 6'd63}, 5'd1, F3_SLL, 5'd5, OPC_ALUI),
            s_type(12'hFFC, 5'd1, 5'd0, F3_LD, OPC_STORE),
            i_type(12'hFFC, 5'd0, F3_LD, 5'd6, OPC_LOAD),
            i_type(12'hFFF, 5'd0, F3_LB, 5'd7, OPC_LOAD),
            i_type(12'hFFE, 5'd0, F3_LHU, 5'd8, OPC_LOAD),
            i_type(12'hFFC, 5'd0, F3_LWU, 5'd9, OPC_LOAD),
            r_type(F7_ALT, 5'd1, 5'd0, F3_ADD, 5'd10, OPC_ALURW),
            r_type(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd11, OPC_ALUR),
            i_type({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd12, OPC_ALUIW),
            s_type(12'hFFE, 5'd1, 5'd1, F3_BLT, OPC_BRANCH),
            s_type(12'h7FE, 5'd2, 5'd2, F3_BGEU, OPC_BRANCH),
            {1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL},
            i_type(12'h7FF, 5'd1, F3_ADD, 5'd13, OPC_JALR),
            {20'hFFFFF, 5'd14, OPC_AUIPC},
            WORD_ECALL,
            WORD_EBREAK,
            i_type(12'h0FF, 5'd0, 3'd0, 5'd0, OPC_FENCE),
            r_type(7'h01, 5'd2, 5'd1, F3_ADD, 5'd15, OPC_ALUR),
            i_type(12'h000, 5'd0, F3_BAD, 5'd16, OPC_LOAD),
            32'hFFFF_FFFF,
            32'h0000_0000
        };
        foreach (directed[i]) send_word(directed[i], 1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: load_start('1);
                1: load_start('0);
                2: load_start({$urandom, $urandom});
                default: load_start(64'h0000_0000_0000_0FF0);
            endcase
            for (int n = 0; n < 250; n++) begin
                if (n == 125) drain();
                // Some stretches run without sender gaps.
                send_word(random_word(), phase != 1 || n > 60);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("rv64i_integer_execute_core: match");
        end else begin
            $display("rv64i_integer_execute_core: mismatch");
        end
        $finish;
    end
endmodule
